// ----- src/i8fq_pkg.sv -----
package i8fq_pkg;

	// default sizes
	localparam int MAX_CHANNELS_DEF = 64;
	localparam int PAD_ALIGN_DEF    = 16;

	// results per frame are capped at RESULT_LIMIT, index counts 0..RESULT_LIMIT-1
	localparam int RESULT_LIMIT = 64;
	localparam int RES_W        = $clog2(RESULT_LIMIT + 1);

	// field widths
	localparam int SAMPLE_W = 16;
	localparam int QVAL_W   = 8;
	localparam int AMAX_W   = 16;

	// quantizer scale and clamp
	localparam int Q_MAX = 127;

	// restoring divider: quotient never exceeds Q_MAX, so seven bits
	localparam int DIV_STEPS = 7;
	localparam int DIV_CNT_W = 3;
	localparam int REM_W     = 24;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_FILL   = 2'd1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last_in;
	} in_item_t;

	typedef struct packed {
		logic signed [QVAL_W-1:0] qvalue;
		logic                     is_padding;
		logic [AMAX_W-1:0]        frame_amax;
		logic                     overflow;
		logic                     last_out;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_CAPTURE,
		ST_FETCH,
		ST_LOAD,
		ST_DIV,
		ST_ROUND,
		ST_EMIT
	} state_t;

endpackage

// ----- src/int8_frame_activation_quantizer.sv -----
// Input: one sample item per cycle while a frame is being captured; stall stays high
// from the last sample until the last result of the frame is in the output register.
// Output: a sample lane passes store read, load, 7 radix-2 divider steps, rounding and
// the output register, a padding lane only the output register; emit waits on stall.
// Reset clears the frame counters, amax, overflow flag, output valid and sets pad_enable
// to 1, pad_fill to 0. The sample store is not cleared: entries are written before read.
module int8_frame_activation_quantizer #(
	parameter int MAX_CHANNELS = i8fq_pkg::MAX_CHANNELS_DEF,
	parameter int PAD_ALIGN    = i8fq_pkg::PAD_ALIGN_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               sample_valid,
	output logic                               sample_stall,
	input  i8fq_pkg::in_item_t                 sample_item,
	output logic                               result_valid,
	input  logic                               result_stall,
	output i8fq_pkg::out_item_t                result_item,
	input  logic                               cfg_we,
	input  logic [i8fq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [i8fq_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
	localparam int ADDR_W = $clog2(MAX_CHANNELS);
	localparam int GRP_W  = (PAD_ALIGN > 1) ? $clog2(PAD_ALIGN) : 1;
	localparam int RES_W  = i8fq_pkg::RES_W;
	localparam int REM_W  = i8fq_pkg::REM_W;
	localparam int AMAX_W = i8fq_pkg::AMAX_W;
	localparam int QVAL_W = i8fq_pkg::QVAL_W;
	localparam int SMP_W  = i8fq_pkg::SAMPLE_W;
	localparam int QUO_W  = i8fq_pkg::DIV_STEPS;

	i8fq_pkg::state_t state_q, state_nxt;

	// configuration
	logic              pad_enable_q;
	logic [QVAL_W-1:0] pad_fill_q;

	// frame state
	logic [CNT_W-1:0]  cnt_q;
	logic [AMAX_W-1:0] amax_q;
	logic              ovf_q;

	// emit sequencing
	logic [RES_W-1:0]  k_q;
	logic [GRP_W-1:0]  grp_q;
	logic [i8fq_pkg::DIV_CNT_W-1:0] div_cnt_q;

	// datapath
	logic [SMP_W-1:0]  store_mem [MAX_CHANNELS];
	logic [SMP_W-1:0]  rd_data_q;
	logic [REM_W-1:0]  rem_q;
	logic [REM_W-1:0]  den_q;
	logic [QUO_W-1:0]  quo_q;
	logic              neg_q;
	logic [QVAL_W-1:0] qv_q;

	// output register
	logic                out_valid_q;
	i8fq_pkg::out_item_t out_item_q;

	// control
	logic cap_fire;
	logic store_we;
	logic fetch_go;
	logic emit_fire;
	logic out_free;
	logic sample_lane;
	logic grp_wrap;
	logic last_lane;
	logic [RES_W-1:0] k_next;
	logic [GRP_W-1:0] grp_next;

	// datapath intermediates
	logic [SMP_W:0]    in_mag;
	logic [SMP_W:0]    rd_mag;
	logic [REM_W-1:0]  num;
	logic              div_ge;
	logic [AMAX_W:0]   twice_rem;
	logic              round_up;
	logic [QVAL_W-1:0] q_rnd;
	logic [QVAL_W-1:0] q_clamp;

	assign out_free     = !out_valid_q || !result_stall;
	assign result_valid = out_valid_q;
	assign result_item  = out_item_q;

	// lane bookkeeping for the current result
	assign sample_lane = k_q < RES_W'(cnt_q);
	assign k_next      = k_q + RES_W'(1);
	assign grp_wrap    = grp_q == GRP_W'(PAD_ALIGN - 1);
	assign grp_next    = grp_wrap ? '0 : grp_q + GRP_W'(1);
	assign last_lane   = (k_next == RES_W'(i8fq_pkg::RESULT_LIMIT)) ||
		(sample_lane ? ((k_next == RES_W'(cnt_q)) && (!pad_enable_q || grp_wrap))
		             : grp_wrap);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			i8fq_pkg::ST_CAPTURE: begin
				if (cap_fire && sample_item.last_in)
					state_nxt = i8fq_pkg::ST_FETCH;
			end
			i8fq_pkg::ST_FETCH: begin
				state_nxt = sample_lane ? i8fq_pkg::ST_LOAD : i8fq_pkg::ST_EMIT;
			end
			i8fq_pkg::ST_LOAD: begin
				state_nxt = i8fq_pkg::ST_DIV;
			end
			i8fq_pkg::ST_DIV: begin
				if (div_cnt_q == i8fq_pkg::DIV_CNT_W'(i8fq_pkg::DIV_STEPS - 1))
					state_nxt = i8fq_pkg::ST_ROUND;
			end
			i8fq_pkg::ST_ROUND: begin
				state_nxt = i8fq_pkg::ST_EMIT;
			end
			i8fq_pkg::ST_EMIT: begin
				if (out_free)
					state_nxt = last_lane ? i8fq_pkg::ST_CAPTURE : i8fq_pkg::ST_FETCH;
			end
			default: begin
				state_nxt = i8fq_pkg::ST_CAPTURE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		sample_stall = 1'b1;
		fetch_go     = 1'b0;
		emit_fire    = 1'b0;
		case (state_q)
			i8fq_pkg::ST_CAPTURE: sample_stall = 1'b0;
			i8fq_pkg::ST_FETCH:   fetch_go     = sample_lane;
			i8fq_pkg::ST_EMIT:    emit_fire    = out_free;
			default: begin
				sample_stall = 1'b1;
			end
		endcase
	end

	assign cap_fire = sample_valid && !sample_stall;
	assign store_we = cap_fire && (cnt_q < CNT_W'(MAX_CHANNELS));

	// magnitudes, -32768 maps to 32768
	assign in_mag = sample_item.sample[SMP_W-1] ?
		((SMP_W+1)'(1) << SMP_W) - {1'b0, sample_item.sample} : {1'b0, sample_item.sample};
	assign rd_mag = rd_data_q[SMP_W-1] ?
		((SMP_W+1)'(1) << SMP_W) - {1'b0, rd_data_q} : {1'b0, rd_data_q};

	// mag * 127 as a shift and subtract
	assign num = (REM_W'(rd_mag) << 7) - REM_W'(rd_mag);

	// one restoring divider step
	assign div_ge = rem_q >= den_q;

	// round half to even, clamp, restore sign
	assign twice_rem = {rem_q[AMAX_W-1:0], 1'b0};
	assign round_up  = (twice_rem > {1'b0, amax_q}) ||
		((twice_rem == {1'b0, amax_q}) && quo_q[0]);
	assign q_rnd     = {1'b0, quo_q} + QVAL_W'(round_up);
	assign q_clamp   = (q_rnd > QVAL_W'(i8fq_pkg::Q_MAX)) ? QVAL_W'(i8fq_pkg::Q_MAX) : q_rnd;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= i8fq_pkg::ST_CAPTURE;
			pad_enable_q <= 1'b1;
			pad_fill_q   <= '0;
			cnt_q        <= '0;
			amax_q       <= '0;
			ovf_q        <= 1'b0;
			k_q          <= '0;
			grp_q        <= '0;
			div_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;

			// configuration writes, other indexes ignored
			if (cfg_we) begin
				case (cfg_index)
					i8fq_pkg::REG_PAD_ENABLE: pad_enable_q <= cfg_data[0];
					i8fq_pkg::REG_PAD_FILL:   pad_fill_q   <= cfg_data;
					default: begin
					end
				endcase
			end

			// capture side
			if (store_we) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (in_mag[AMAX_W-1:0] > amax_q)
					amax_q <= in_mag[AMAX_W-1:0];
			end else if (cap_fire) begin
				ovf_q <= 1'b1;
			end

			// divider step count
			if (state_q == i8fq_pkg::ST_LOAD)
				div_cnt_q <= '0;
			else if (state_q == i8fq_pkg::ST_DIV)
				div_cnt_q <= div_cnt_q + i8fq_pkg::DIV_CNT_W'(1);

			// emit side, frame state clears after the last result
			if (emit_fire) begin
				if (last_lane) begin
					k_q    <= '0;
					grp_q  <= '0;
					cnt_q  <= '0;
					amax_q <= '0;
					ovf_q  <= 1'b0;
				end else begin
					k_q   <= k_next;
					grp_q <= grp_next;
				end
			end

			// output valid
			if (emit_fire)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
		end
	end

	// sample store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (store_we)
			store_mem[cnt_q[ADDR_W-1:0]] <= sample_item.sample;
		if (fetch_go)
			rd_data_q <= store_mem[k_q[ADDR_W-1:0]];
	end

	// divider datapath and output payload
	always_ff @(posedge clk) begin
		case (state_q)
			i8fq_pkg::ST_LOAD: begin
				rem_q <= num;
				den_q <= REM_W'(amax_q) << (QUO_W - 1);
				quo_q <= '0;
				neg_q <= rd_data_q[SMP_W-1];
			end
			i8fq_pkg::ST_DIV: begin
				if (div_ge)
					rem_q <= rem_q - den_q;
				den_q <= den_q >> 1;
				quo_q <= {quo_q[QUO_W-2:0], div_ge};
			end
			i8fq_pkg::ST_ROUND: begin
				if (amax_q == '0)
					qv_q <= '0;
				else
					qv_q <= neg_q ? (QVAL_W'(0) - q_clamp) : q_clamp;
			end
			default: begin
			end
		endcase

		if (emit_fire) begin
			out_item_q.qvalue     <= sample_lane ? qv_q : pad_fill_q;
			out_item_q.is_padding <= !sample_lane;
			out_item_q.frame_amax <= amax_q;
			out_item_q.overflow   <= ovf_q;
			out_item_q.last_out   <= last_lane;
		end
	end

endmodule
